### src/erh_pkg.sv
// ----------------------------------------------------------------------------
// erh_pkg
// Shared types, constants and controller codes for the euclidean rhythm
// onset generator.
// ----------------------------------------------------------------------------
package erh_pkg;

    localparam int MAX_STEPS = 64;
    localparam int STEP_W    = 7;     // width of steps and clamped pulse count
    localparam int POS_W     = 6;     // width of an onset position
    localparam int DIV_W     = 12;    // dividend width of the remainder unit
    localparam int DIV_CW    = 4;     // iteration counter width

    typedef struct packed {
        logic signed [7:0] pulses;
        logic [6:0]        steps;
        logic signed [7:0] rotation;
    } in_t;

    typedef struct packed {
        logic [5:0] position;
        logic       is_last;
        logic       empty_res;
    } out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ROT_DIV,
        ST_ROT_FIX,
        ST_IDX_MUL,
        ST_IDX_DIV,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_EMPTY
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;        // capture and clamp the request
        logic div_rot;      // start remainder of |rotation| by steps
        logic fix_rot;      // form the starting step index
        logic div_idx;      // start remainder of index * pulses by steps
        logic scan_init;    // load accumulator, clear position and count
        logic scan_adv;     // move to the next position
        logic out_load;     // load an onset result
        logic out_empty;    // load the empty result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic k_zero;
        logic div_busy;
        logic onset;
        logic last_hit;
        logic out_free;
    } sts_t;

endpackage

### src/erh_mod_unit.sv
// ----------------------------------------------------------------------------
// erh_mod_unit
// Restoring remainder unit: one dividend bit per cycle. Divisor must be
// nonzero and at most MAX_STEPS.
// ----------------------------------------------------------------------------
module erh_mod_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [erh_pkg::DIV_W-1:0] dividend,
    input  logic [erh_pkg::STEP_W-1:0] divisor,
    output logic                      busy,
    output logic [erh_pkg::STEP_W-1:0] remainder
);

    logic [erh_pkg::DIV_W-1:0]  dvd_reg, dvd_next;
    logic [erh_pkg::STEP_W-1:0] rem_reg, rem_next;
    logic [erh_pkg::DIV_CW-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [erh_pkg::STEP_W-1:0] trial;

    // remainder stays below the divisor, so its top bit is always clear
    assign trial = {rem_reg[erh_pkg::STEP_W-2:0], dvd_reg[erh_pkg::DIV_W-1]};

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = erh_pkg::DIV_CW'(erh_pkg::DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[erh_pkg::DIV_W-2:0], 1'b0};
            rem_next = (trial >= divisor) ? trial - divisor : trial;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == erh_pkg::DIV_CW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

### src/erh_datapath.sv
// ----------------------------------------------------------------------------
// erh_datapath
// Request registers, starting-index arithmetic, incremental onset test and
// the output register.
// ----------------------------------------------------------------------------
module erh_datapath (
    input  logic           aclk,
    input  logic           aresetn,
    input  erh_pkg::in_t   s_data,
    input  erh_pkg::cmd_t  cmd,
    output erh_pkg::sts_t  sts,
    output logic           m_valid,
    input  logic           m_ready,
    output erh_pkg::out_t  m_data
);

    logic [erh_pkg::STEP_W-1:0] k_reg, n_reg, n_clamp, k_clamp;
    logic                       neg_reg;
    logic [7:0]                 mag_reg, mag_in;
    logic [erh_pkg::POS_W-1:0]  idx_reg, idx_next;
    logic [erh_pkg::POS_W-1:0]  acc_reg, p_reg;
    logic [erh_pkg::STEP_W-1:0] cnt_reg;
    logic [erh_pkg::STEP_W-1:0] acc_sum, acc_wrap;
    logic [erh_pkg::POS_W+erh_pkg::STEP_W-1:0] prod;
    logic                       div_start;
    logic [erh_pkg::DIV_W-1:0]  div_dvd;
    logic                       div_busy;
    logic [erh_pkg::STEP_W-1:0] div_rem;
    logic                       m_valid_reg;
    erh_pkg::out_t              m_data_reg;

    // clamp the request
    always_comb begin
        if (s_data.steps > erh_pkg::STEP_W'(erh_pkg::MAX_STEPS)) begin
            n_clamp = erh_pkg::STEP_W'(erh_pkg::MAX_STEPS);
        end else begin
            n_clamp = s_data.steps;
        end
        if (s_data.pulses[7]) begin
            k_clamp = '0;
        end else if (s_data.pulses[6:0] > n_clamp) begin
            k_clamp = n_clamp;
        end else begin
            k_clamp = s_data.pulses[6:0];
        end
        mag_in = s_data.rotation[7] ? 8'(-s_data.rotation) : s_data.rotation;
    end

    // p = i + r  <=>  i = p + (-rotation) mod n, so the scan starts at that step
    always_comb begin
        if (neg_reg) begin
            idx_next = div_rem[erh_pkg::POS_W-1:0];
        end else if (div_rem == '0) begin
            idx_next = '0;
        end else begin
            idx_next = erh_pkg::POS_W'(n_reg - div_rem);
        end
    end

    assign prod      = idx_reg * k_reg;
    assign div_start = cmd.div_rot | cmd.div_idx;
    assign div_dvd   = cmd.div_rot ? erh_pkg::DIV_W'(mag_reg)
                                   : prod[erh_pkg::DIV_W-1:0];

    erh_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (n_reg),
        .busy      (div_busy),
        .remainder (div_rem)
    );

    assign acc_sum  = {1'b0, acc_reg} + k_reg;
    assign acc_wrap = (acc_sum >= n_reg) ? acc_sum - n_reg : acc_sum;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            k_reg   <= k_clamp;
            n_reg   <= n_clamp;
            neg_reg <= s_data.rotation[7];
            mag_reg <= mag_in;
        end
        if (cmd.fix_rot) begin
            idx_reg <= idx_next;
        end
        if (cmd.scan_init) begin
            acc_reg <= div_rem[erh_pkg::POS_W-1:0];
            p_reg   <= '0;
            cnt_reg <= '0;
        end else if (cmd.scan_adv) begin
            acc_reg <= acc_wrap[erh_pkg::POS_W-1:0];
            p_reg   <= p_reg + 1'b1;
            if (cmd.out_load) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load || cmd.out_empty) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_data_reg.position  <= p_reg;
            m_data_reg.is_last   <= sts.last_hit;
            m_data_reg.empty_res <= 1'b0;
        end else if (cmd.out_empty) begin
            m_data_reg.position  <= '0;
            m_data_reg.is_last   <= 1'b1;
            m_data_reg.empty_res <= 1'b1;
        end
    end

    always_comb begin
        sts.k_zero   = (k_reg == '0);
        sts.div_busy = div_busy;
        sts.onset    = ({1'b0, acc_reg} < k_reg);
        // exactly k onsets exist in the pattern
        sts.last_hit = (cnt_reg + 1'b1 == k_reg);
        sts.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### src/erh_ctrl.sv
// ----------------------------------------------------------------------------
// erh_ctrl
// Sequencer: clamp check, two remainder passes, then a scan over the
// positions that emits one beat per onset, or one empty beat if there are none.
// ----------------------------------------------------------------------------
module erh_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  erh_pkg::sts_t  sts,
    output erh_pkg::cmd_t  cmd
);

    erh_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            erh_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = erh_pkg::ST_CHECK;
                end
            end
            erh_pkg::ST_CHECK: begin
                state_next = sts.k_zero ? erh_pkg::ST_EMPTY : erh_pkg::ST_ROT_DIV;
            end
            erh_pkg::ST_ROT_DIV: begin
                if (!sts.div_busy) begin
                    state_next = erh_pkg::ST_ROT_FIX;
                end
            end
            erh_pkg::ST_ROT_FIX: begin
                state_next = erh_pkg::ST_IDX_MUL;
            end
            erh_pkg::ST_IDX_MUL: begin
                state_next = erh_pkg::ST_IDX_DIV;
            end
            erh_pkg::ST_IDX_DIV: begin
                if (!sts.div_busy) begin
                    state_next = erh_pkg::ST_SCAN_INIT;
                end
            end
            erh_pkg::ST_SCAN_INIT: begin
                state_next = erh_pkg::ST_SCAN;
            end
            erh_pkg::ST_SCAN: begin
                if (sts.onset && sts.out_free && sts.last_hit) begin
                    state_next = erh_pkg::ST_IDLE;
                end
            end
            erh_pkg::ST_EMPTY: begin
                if (sts.out_free) begin
                    state_next = erh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = erh_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            erh_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.latch = s_valid;
            end
            erh_pkg::ST_CHECK: begin
                cmd.div_rot = !sts.k_zero;
            end
            erh_pkg::ST_ROT_FIX: begin
                cmd.fix_rot = 1'b1;
            end
            erh_pkg::ST_IDX_MUL: begin
                cmd.div_idx = 1'b1;
            end
            erh_pkg::ST_SCAN_INIT: begin
                cmd.scan_init = 1'b1;
            end
            erh_pkg::ST_SCAN: begin
                // an onset waits until the output register can take it
                if (sts.onset) begin
                    cmd.out_load = sts.out_free;
                    cmd.scan_adv = sts.out_free;
                end else begin
                    cmd.scan_adv = 1'b1;
                end
            end
            erh_pkg::ST_EMPTY: begin
                cmd.out_empty = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= erh_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### src/euclidean_rhythm_onsets.sv
// ----------------------------------------------------------------------------
// euclidean_rhythm_onsets
// Euclidean rhythm onset generator: one request in, its onset positions out
// in ascending order, the last beat marked.
// ----------------------------------------------------------------------------
// One request at a time. After the request beat the block runs the clamp
// check, reduces the rotation modulo the step count and then the starting
// index times the pulse count (both in a shared one-bit-per-cycle remainder
// unit), passes the setup states ROT_FIX, IDX_MUL and SCAN_INIT, then scans
// one position per cycle, holding while an onset waits for the output
// register, until the last onset is emitted, and returns to idle to take
// the next request. A pattern with no onsets returns its single empty beat
// once the output register is free. A new request is taken once the last
// result is in the output register.
module euclidean_rhythm_onsets (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  erh_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output erh_pkg::out_t m_data
);

    erh_pkg::cmd_t cmd;
    erh_pkg::sts_t sts;

    erh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    erh_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
